FILE: rtl/core/sequential_list_block_insert_delete_defines.svh
// Assertion macros shared by the list block RTL.
`ifndef SEQUENTIAL_LIST_BLOCK_INSERT_DELETE_DEFINES_SVH
`define SEQUENTIAL_LIST_BLOCK_INSERT_DELETE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define SLBID_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define SLBID_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/slbid_pkg.sv
// Types and constants for the ordered list block.
package slbid_pkg;

  localparam int unsigned VAL_W = 32;
  localparam int unsigned POS_W = 11;
  localparam int unsigned TREE_RADIX = 32;
  localparam int unsigned TREE_LEVELS = 4;
  localparam int unsigned WAIT_W = $clog2(TREE_LEVELS + 1);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DEL,
    S_READ,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic up;
    logic down;
  } shift_t;

endpackage

FILE: rtl/core/slbid_cell.sv
// One list cell: holds one entry and shifts it up or down the row.
module slbid_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned IDX_W = 10
) (
  input  logic                          clk,
  input  slbid_pkg::shift_t             op_i,
  input  logic [IDX_W-1:0]              slot_i,
  input  logic [slbid_pkg::VAL_W-1:0]   value_i,
  input  logic [slbid_pkg::VAL_W-1:0]   prev_i,
  input  logic [slbid_pkg::VAL_W-1:0]   next_i,
  output logic [slbid_pkg::VAL_W-1:0]   data_o,
  output logic [slbid_pkg::VAL_W-1:0]   tap_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [slbid_pkg::VAL_W-1:0] data_r;
  logic [slbid_pkg::VAL_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (op_i.up) begin
      if (MY_IDX == slot_i) begin
        data_nxt = value_i;
      end else if (MY_IDX > slot_i) begin
        data_nxt = prev_i;
      end
    end else if (op_i.down && (MY_IDX >= slot_i)) begin
      data_nxt = next_i;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;
  assign tap_o  = (slot_i == MY_IDX) ? data_r : '0;

endmodule

FILE: rtl/core/slbid_tree.sv
// Registered four-level OR tree that collects the one selected cell tap.
module slbid_tree #(
  parameter int unsigned N = 1024
) (
  input  logic                        clk,
  input  logic [slbid_pkg::VAL_W-1:0] leaf_i [N],
  output logic [slbid_pkg::VAL_W-1:0] dout_o
);

  localparam int unsigned R  = slbid_pkg::TREE_RADIX;
  localparam int unsigned L1 = (N + R - 1) / R;
  localparam int unsigned L2 = (L1 + R - 1) / R;
  localparam int unsigned L3 = (L2 + R - 1) / R;
  localparam int unsigned L4 = (L3 + R - 1) / R;

  logic [slbid_pkg::VAL_W-1:0] l1_r [L1];
  logic [slbid_pkg::VAL_W-1:0] l2_r [L2];
  logic [slbid_pkg::VAL_W-1:0] l3_r [L3];
  logic [slbid_pkg::VAL_W-1:0] l4_r [L4];

  genvar i;

  for (i = 0; i < L1; i++) begin : g_l1
    logic [slbid_pkg::VAL_W-1:0] acc;
    always_comb begin
      acc = '0;
      for (int j = 0; j < R; j++) begin
        if (i * R + j < N) begin
          acc = acc | leaf_i[i * R + j];
        end
      end
    end
    always_ff @(posedge clk) begin
      l1_r[i] <= acc;
    end
  end

  for (i = 0; i < L2; i++) begin : g_l2
    logic [slbid_pkg::VAL_W-1:0] acc;
    always_comb begin
      acc = '0;
      for (int j = 0; j < R; j++) begin
        if (i * R + j < L1) begin
          acc = acc | l1_r[i * R + j];
        end
      end
    end
    always_ff @(posedge clk) begin
      l2_r[i] <= acc;
    end
  end

  for (i = 0; i < L3; i++) begin : g_l3
    logic [slbid_pkg::VAL_W-1:0] acc;
    always_comb begin
      acc = '0;
      for (int j = 0; j < R; j++) begin
        if (i * R + j < L2) begin
          acc = acc | l2_r[i * R + j];
        end
      end
    end
    always_ff @(posedge clk) begin
      l3_r[i] <= acc;
    end
  end

  for (i = 0; i < L4; i++) begin : g_l4
    logic [slbid_pkg::VAL_W-1:0] acc;
    always_comb begin
      acc = '0;
      for (int j = 0; j < R; j++) begin
        if (i * R + j < L3) begin
          acc = acc | l3_r[i * R + j];
        end
      end
    end
    always_ff @(posedge clk) begin
      l4_r[i] <= acc;
    end
  end

  assign dout_o = l4_r[0];

endmodule

FILE: rtl/core/sequential_list_block_insert_delete.sv
// Top level of the ordered list block: control sequencer, cell row and read tree.
// The list lives in a row of CAPACITY cells, one entry per cell. A request is
// taken when in_valid is high and in_stall is low, and one request is handled at
// a time. An insert, and any request that fails or changes nothing, is handled
// in S_EXEC, since the whole row shifts up together. A delete of N entries stays
// in S_DEL while the row shifts down one place per cycle, N places in all. A read
// waits in S_READ on the four registered levels of the OR tree that collects the
// selected cell. The result register lets a finished result wait on out_stall
// while the next request is already taken.
`include "sequential_list_block_insert_delete_defines.svh"

module sequential_list_block_insert_delete #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_opcode,
  input  logic [slbid_pkg::POS_W-1:0]         in_position,
  input  logic [slbid_pkg::POS_W-1:0]         in_count,
  input  logic signed [slbid_pkg::VAL_W-1:0]  in_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          out_status,
  output logic [slbid_pkg::POS_W-1:0]         out_list_size,
  output logic signed [slbid_pkg::VAL_W-1:0]  out_read_value
);

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W =
    ((CNT_W > slbid_pkg::POS_W) ? CNT_W : slbid_pkg::POS_W) + 1;

  localparam logic [CMP_W-1:0] CAP_E = CMP_W'(CAPACITY);

  slbid_pkg::state_t state_r, state_nxt;

  logic [1:0]                      req_op_r;
  logic [slbid_pkg::POS_W-1:0]     req_pos_r;
  logic [slbid_pkg::POS_W-1:0]     req_cnt_r;
  logic [slbid_pkg::VAL_W-1:0]     req_val_r;

  logic [CNT_W-1:0]                count_r, count_nxt;
  logic [CMP_W-1:0]                bnp_r, bnp_nxt;
  logic [slbid_pkg::POS_W-1:0]     brem_r, brem_nxt;
  logic [CNT_W-1:0]                del_left_r, del_left_nxt;
  logic [slbid_pkg::WAIT_W-1:0]    wait_r, wait_nxt;
  logic [IDX_W-1:0]                slot_r, slot_nxt;
  slbid_pkg::status_t              res_status_r, res_status_nxt;
  logic [slbid_pkg::VAL_W-1:0]     res_rd_r, res_rd_nxt;

  logic                            out_valid_r;
  logic [1:0]                      out_status_r;
  logic [slbid_pkg::POS_W-1:0]     out_size_r;
  logic [slbid_pkg::VAL_W-1:0]     out_rd_r;

  logic                            out_free;
  logic                            out_load;
  slbid_pkg::status_t              out_status_sel;
  logic [slbid_pkg::VAL_W-1:0]     out_rd_sel;
  logic [CMP_W-1:0]                size_ext;

  slbid_pkg::status_t              ex_status;
  logic                            ex_insert;
  logic                            ex_del;
  logic                            ex_read;
  logic [IDX_W-1:0]                ex_slot;

  logic [CMP_W-1:0]                pos_e;
  logic [CMP_W-1:0]                cnt_e;
  logic [CMP_W-1:0]                count_e;

  slbid_pkg::shift_t               cell_op;
  logic [IDX_W-1:0]                cell_slot;
  logic [slbid_pkg::VAL_W-1:0]     cell_data [CAPACITY];
  logic [slbid_pkg::VAL_W-1:0]     cell_prev [CAPACITY];
  logic [slbid_pkg::VAL_W-1:0]     cell_next [CAPACITY];
  logic [slbid_pkg::VAL_W-1:0]     cell_tap  [CAPACITY];
  logic [slbid_pkg::VAL_W-1:0]     tree_out;

  assign in_stall = (state_r != slbid_pkg::S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  assign pos_e   = CMP_W'(req_pos_r);
  assign cnt_e   = CMP_W'(req_cnt_r);
  assign count_e = CMP_W'(count_r);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    bnp_nxt        = bnp_r;
    brem_nxt       = brem_r;
    del_left_nxt   = del_left_r;
    wait_nxt       = wait_r;
    slot_nxt       = slot_r;
    res_status_nxt = res_status_r;
    res_rd_nxt     = res_rd_r;
    cell_op        = '0;
    cell_slot      = slot_r;
    out_load       = 1'b0;
    out_status_sel = res_status_r;
    out_rd_sel     = res_rd_r;
    ex_status      = slbid_pkg::ST_OK;
    ex_insert      = 1'b0;
    ex_del         = 1'b0;
    ex_read        = 1'b0;
    ex_slot        = '0;

    unique case (state_r)
      slbid_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = slbid_pkg::S_EXEC;
        end
      end

      slbid_pkg::S_EXEC: begin
        if (req_op_r != slbid_pkg::OP_INSERT) begin
          brem_nxt = '0;
        end
        unique case (req_op_r)
          slbid_pkg::OP_INSERT: begin
            if (brem_r != '0) begin
              if ((count_e >= CAP_E) || (bnp_r == '0) ||
                  (bnp_r > count_e + CMP_W'(1))) begin
                ex_status = slbid_pkg::ST_FULL;
                brem_nxt  = '0;
              end else begin
                ex_insert = 1'b1;
                ex_slot   = IDX_W'(bnp_r - CMP_W'(1));
                bnp_nxt   = bnp_r + CMP_W'(1);
                brem_nxt  = brem_r - slbid_pkg::POS_W'(1);
              end
            end else if ((pos_e == '0) || (pos_e > count_e + CMP_W'(1)) ||
                         (cnt_e == '0)) begin
              ex_status = slbid_pkg::ST_RANGE;
            end else if (cnt_e > CAP_E - count_e) begin
              ex_status = slbid_pkg::ST_FULL;
            end else begin
              ex_insert = 1'b1;
              ex_slot   = IDX_W'(pos_e - CMP_W'(1));
              bnp_nxt   = pos_e + CMP_W'(1);
              brem_nxt  = req_cnt_r - slbid_pkg::POS_W'(1);
            end
          end
          slbid_pkg::OP_DELETE: begin
            if ((pos_e == '0) || (pos_e > count_e) ||
                (cnt_e > count_e - pos_e + CMP_W'(1))) begin
              ex_status = slbid_pkg::ST_RANGE;
            end else if (cnt_e != '0) begin
              ex_del       = 1'b1;
              ex_slot      = IDX_W'(pos_e - CMP_W'(1));
              count_nxt    = count_r - CNT_W'(cnt_e);
              del_left_nxt = CNT_W'(cnt_e);
            end
          end
          slbid_pkg::OP_READ: begin
            if ((pos_e == '0) || (pos_e > count_e)) begin
              ex_status = slbid_pkg::ST_RANGE;
            end else begin
              ex_read = 1'b1;
              ex_slot = IDX_W'(pos_e - CMP_W'(1));
            end
          end
          default: begin
            ex_status = slbid_pkg::ST_RANGE;
          end
        endcase

        if (ex_insert) begin
          cell_op.up = 1'b1;
          count_nxt  = count_r + CNT_W'(1);
        end
        cell_slot      = ex_slot;
        slot_nxt       = ex_slot;
        res_status_nxt = ex_status;
        res_rd_nxt     = '0;

        if (ex_del) begin
          state_nxt = slbid_pkg::S_DEL;
        end else if (ex_read) begin
          wait_nxt  = '0;
          state_nxt = slbid_pkg::S_READ;
        end else if (out_free) begin
          out_load       = 1'b1;
          out_status_sel = ex_status;
          out_rd_sel     = '0;
          state_nxt      = slbid_pkg::S_IDLE;
        end else begin
          state_nxt = slbid_pkg::S_RESULT;
        end
      end

      slbid_pkg::S_DEL: begin
        cell_op.down = 1'b1;
        del_left_nxt = del_left_r - CNT_W'(1);
        if (del_left_r == CNT_W'(1)) begin
          state_nxt = slbid_pkg::S_RESULT;
        end
      end

      slbid_pkg::S_READ: begin
        wait_nxt = wait_r + slbid_pkg::WAIT_W'(1);
        if (wait_r == slbid_pkg::WAIT_W'(slbid_pkg::TREE_LEVELS)) begin
          res_rd_nxt = tree_out;
          state_nxt  = slbid_pkg::S_RESULT;
        end
      end

      slbid_pkg::S_RESULT: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = slbid_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = slbid_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= slbid_pkg::S_IDLE;
      count_r <= '0;
      bnp_r   <= '0;
      brem_r  <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      bnp_r   <= bnp_nxt;
      brem_r  <= brem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_op_r  <= in_opcode;
      req_pos_r <= in_position;
      req_cnt_r <= in_count;
      req_val_r <= in_value;
    end
    del_left_r   <= del_left_nxt;
    wait_r       <= wait_nxt;
    slot_r       <= slot_nxt;
    res_status_r <= res_status_nxt;
    res_rd_r     <= res_rd_nxt;
  end

  assign size_ext = CMP_W'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= out_status_sel;
      out_size_r   <= size_ext[slbid_pkg::POS_W-1:0];
      out_rd_r     <= out_rd_sel;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_list_size  = out_size_r;
  assign out_read_value = out_rd_r;

  genvar k;
  for (k = 0; k < CAPACITY; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign cell_prev[k] = '0;
    end else begin : g_body
      assign cell_prev[k] = cell_data[k-1];
    end
    if (k == CAPACITY - 1) begin : g_tail
      assign cell_next[k] = cell_data[k];
    end else begin : g_mid
      assign cell_next[k] = cell_data[k+1];
    end

    slbid_cell #(
      .INDEX (k),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk     (clk),
      .op_i    (cell_op),
      .slot_i  (cell_slot),
      .value_i (req_val_r),
      .prev_i  (cell_prev[k]),
      .next_i  (cell_next[k]),
      .data_o  (cell_data[k]),
      .tap_o   (cell_tap[k])
    );
  end

  slbid_tree #(
    .N (CAPACITY)
  ) u_tree (
    .clk    (clk),
    .leaf_i (cell_tap),
    .dout_o (tree_out)
  );

  `SLBID_ASSERT_IMPL(a_count_bound, 1'b1, CMP_W'(count_r) <= CAP_E, "List size above capacity.")
  `SLBID_ASSERT_NEXT(a_accept_exec, in_valid && !in_stall, state_r == slbid_pkg::S_EXEC, "Accepted request did not enter execution.")
  `SLBID_ASSERT_IMPL(a_del_left, state_r == slbid_pkg::S_DEL, del_left_r != '0, "Delete shift with no entries left.")
  `SLBID_ASSERT_IMPL(a_out_source, $rose(out_valid_r), $past(state_r == slbid_pkg::S_EXEC || state_r == slbid_pkg::S_RESULT), "Result loaded from an unexpected state.")
  `SLBID_ASSERT_IMPL(a_burst_pos, brem_r != '0, bnp_r != '0, "Open burst without a next position.")

endmodule

FILE: tb/sequential_list_block_insert_delete_tb.sv
// Self-checking testbench for the ordered list block, with a built-in list model.
`timescale 1ns / 100ps

module sequential_list_block_insert_delete_tb;

  localparam int unsigned LIST_CAP = 1024;
  localparam logic [1:0] OP_UNKNOWN = 2'd3;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT = 5000;
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    logic [1:0]                        opcode;
    logic [slbid_pkg::POS_W-1:0]        position;
    logic [slbid_pkg::POS_W-1:0]        count;
    logic signed [slbid_pkg::VAL_W-1:0] value;
  } list_req_t;

  typedef struct packed {
    slbid_pkg::status_t                 status;
    logic [slbid_pkg::POS_W-1:0]        list_size;
    logic signed [slbid_pkg::VAL_W-1:0] read_value;
  } list_answer_t;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic [1:0]                         in_opcode = slbid_pkg::OP_READ;
  logic [slbid_pkg::POS_W-1:0]        in_position = '0;
  logic [slbid_pkg::POS_W-1:0]        in_count = '0;
  logic signed [slbid_pkg::VAL_W-1:0] in_value = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic [1:0]                         out_status;
  logic [slbid_pkg::POS_W-1:0]        out_list_size;
  logic signed [slbid_pkg::VAL_W-1:0] out_read_value;

  list_req_t    request_q[$];
  list_answer_t answer_q[$];
  list_req_t    next_req;
  list_answer_t got_answer;

  // Model of the list, updated as requests are accepted.
  logic signed [slbid_pkg::VAL_W-1:0] list_mem [0:LIST_CAP-1];
  int unsigned list_len = 0;
  int unsigned burst_pos = 0;
  int unsigned burst_left = 0;

  // Size-only view used by the generator to aim positions and counts.
  int unsigned plan_len = 0;
  int unsigned plan_burst_left = 0;

  int tx_idle_pct = 13;
  int rx_idle_pct = 49;
  int hold_ask = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  int mismatches = 0;
  int n_requests = 0;
  int n_answers = 0;
  int n_full = 0;
  int n_range = 0;
  int n_reads = 0;
  int unsigned peak_len = 0;

  sequential_list_block_insert_delete #(
    .CAPACITY(LIST_CAP)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_position   (in_position),
    .in_count      (in_count),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_list_size (out_list_size),
    .out_read_value(out_read_value)
  );

  always #1 clk = ~clk;

  task automatic insert_entry(input int unsigned slot,
                              input logic signed [slbid_pkg::VAL_W-1:0] val);
    int unsigned j;
    for (j = list_len; j > slot; j--) list_mem[j] = list_mem[j-1];
    list_mem[slot] = val;
    list_len++;
  endtask

  task automatic update_list_and_answer(input logic [1:0] op,
                                        input logic [slbid_pkg::POS_W-1:0] pos_f,
                                        input logic [slbid_pkg::POS_W-1:0] cnt_f,
                                        input logic signed [slbid_pkg::VAL_W-1:0] val);
    int unsigned p;
    int unsigned c;
    int unsigned j;
    list_answer_t ans;
    p = pos_f;
    c = cnt_f;
    ans.status = slbid_pkg::ST_OK;
    ans.read_value = '0;
    if (op != slbid_pkg::OP_INSERT) burst_left = 0;
    case (op)
      slbid_pkg::OP_INSERT: begin
        if (burst_left != 0) begin
          if (list_len >= LIST_CAP || burst_pos < 1 || burst_pos > list_len + 1) begin
            ans.status = slbid_pkg::ST_FULL;
            burst_left = 0;
          end else begin
            insert_entry(burst_pos - 1, val);
            burst_pos++;
            burst_left--;
          end
        end else if (p < 1 || p > list_len + 1 || c == 0) begin
          ans.status = slbid_pkg::ST_RANGE;
        end else if (c > LIST_CAP - list_len) begin
          ans.status = slbid_pkg::ST_FULL;
        end else begin
          insert_entry(p - 1, val);
          burst_pos = p + 1;
          burst_left = c - 1;
        end
      end
      slbid_pkg::OP_DELETE: begin
        if (p < 1 || p > list_len || c > list_len - (p - 1)) begin
          ans.status = slbid_pkg::ST_RANGE;
        end else if (c != 0) begin
          for (j = p - 1; j + c < list_len; j++) list_mem[j] = list_mem[j+c];
          list_len -= c;
        end
      end
      slbid_pkg::OP_READ: begin
        if (p < 1 || p > list_len) begin
          ans.status = slbid_pkg::ST_RANGE;
        end else begin
          ans.read_value = list_mem[p-1];
          n_reads++;
        end
      end
      default: ans.status = slbid_pkg::ST_RANGE;
    endcase
    ans.list_size = list_len[slbid_pkg::POS_W-1:0];
    if (ans.status == slbid_pkg::ST_FULL) n_full++;
    if (ans.status == slbid_pkg::ST_RANGE) n_range++;
    if (list_len > peak_len) peak_len = list_len;
    answer_q.push_back(ans);
  endtask

  task automatic push_req(input logic [1:0] op, input int p, input int c,
                          input logic [slbid_pkg::VAL_W-1:0] v);
    list_req_t r;
    int unsigned pp;
    int unsigned cc;
    r.opcode = op;
    r.position = p[slbid_pkg::POS_W-1:0];
    r.count = c[slbid_pkg::POS_W-1:0];
    r.value = v;
    request_q.push_back(r);
    pp = r.position;
    cc = r.count;
    if (op != slbid_pkg::OP_INSERT) plan_burst_left = 0;
    if (op == slbid_pkg::OP_INSERT) begin
      if (plan_burst_left != 0) begin
        if (plan_len < LIST_CAP) begin
          plan_len++;
          plan_burst_left--;
        end else begin
          plan_burst_left = 0;
        end
      end else if (pp >= 1 && pp <= plan_len + 1 && cc != 0 && cc <= LIST_CAP - plan_len) begin
        plan_len++;
        plan_burst_left = cc - 1;
      end
    end else if (op == slbid_pkg::OP_DELETE) begin
      if (pp >= 1 && pp <= plan_len && cc <= plan_len - (pp - 1)) plan_len -= cc;
    end
  endtask

  task automatic gen_random(input int n);
    int made;
    int pick;
    int room;
    int c;
    int p;
    int k;
    int lim;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(99);
      room = LIST_CAP - plan_len;
      if (plan_len > 64 && pick < 40) pick = 50;
      if (pick < 40 && room > 0) begin
        lim = (room < 6) ? room : 6;
        c = $urandom_range(1, lim);
        p = $urandom_range(1, plan_len + 1);
        push_req(slbid_pkg::OP_INSERT, p, c, $urandom);
        k = ($urandom_range(9) == 0) ? $urandom_range(0, c - 1) : c - 1;
        repeat (k) begin
          push_req(slbid_pkg::OP_INSERT, $urandom_range(1025), $urandom_range(1024),
                   $urandom);
        end
        made += k + 1;
      end else if (pick < 60 && plan_len > 0) begin
        p = $urandom_range(1, plan_len);
        lim = plan_len - p + 1;
        if (lim > 8 && $urandom_range(7) != 0) lim = 8;
        c = $urandom_range(0, lim);
        push_req(slbid_pkg::OP_DELETE, p, c, $urandom);
        made++;
      end else if (pick < 80) begin
        push_req(slbid_pkg::OP_READ, $urandom_range(0, plan_len + 1), $urandom_range(1024),
                 $urandom);
        made++;
      end else begin
        c = ($urandom_range(1)) ? $urandom_range(1024) : $urandom_range(4);
        push_req(2'($urandom_range(3)), $urandom_range(1025), c, $urandom);
        made++;
      end
    end
  endtask

  task automatic wait_drained();
    while (request_q.size() != 0 || in_valid || answer_q.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        update_list_and_answer(in_opcode, in_position, in_count, in_value);
        n_requests++;
      end
      if (!in_valid || !in_stall) begin
        if (request_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          next_req = request_q.pop_front();
          in_opcode <= next_req.opcode;
          in_position <= next_req.position;
          in_count <= next_req.count;
          in_value <= next_req.value;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_ask != hold_seen) begin
      hold_seen <= hold_ask;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      n_answers++;
      if (answer_q.size() == 0) begin
        $error("result with no request waiting: status %0d size %0d", out_status,
               out_list_size);
        mismatches++;
      end else begin
        got_answer = answer_q.pop_front();
        if (out_status !== got_answer.status) begin
          $error("status: expected %0d, got %0d", got_answer.status, out_status);
          mismatches++;
        end
        if (out_list_size !== got_answer.list_size) begin
          $error("list_size: expected %0d, got %0d", got_answer.list_size, out_list_size);
          mismatches++;
        end
        if (out_read_value !== got_answer.read_value) begin
          $error("read_value: expected %0d, got %0d", got_answer.read_value, out_read_value);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout after %0d cycles without a handshake.", idle_cycles);
        $display("FAIL sequential_list_block_insert_delete");
        $finish;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    push_req(slbid_pkg::OP_READ, 1, 0, 0);
    push_req(slbid_pkg::OP_DELETE, 1, 0, 0);
    push_req(slbid_pkg::OP_INSERT, 0, 1, 1);
    push_req(slbid_pkg::OP_INSERT, 2, 1, 2);
    push_req(slbid_pkg::OP_INSERT, 1, 0, 3);
    push_req(OP_UNKNOWN, 1, 1, 4);
    push_req(slbid_pkg::OP_INSERT, 1, 3, 32'h7fffffff);
    push_req(slbid_pkg::OP_INSERT, 1025, 1024, 32'h80000000);
    push_req(slbid_pkg::OP_INSERT, 0, 0, 32'h00000000);
    push_req(slbid_pkg::OP_INSERT, 1, 1024, 32'hffffffff);
    push_req(slbid_pkg::OP_INSERT, 2, 4, 32'hffffffff);
    push_req(slbid_pkg::OP_INSERT, 0, 0, 32'h00000001);
    push_req(slbid_pkg::OP_READ, 2, 0, 0);
    push_req(slbid_pkg::OP_INSERT, 6, 2, 5);
    push_req(slbid_pkg::OP_DELETE, 1, 0, 0);
    push_req(slbid_pkg::OP_INSERT, 1025, 1, 6);
    push_req(slbid_pkg::OP_READ, 0, 0, 0);
    push_req(slbid_pkg::OP_READ, 7, 0, 0);
    push_req(slbid_pkg::OP_READ, 6, 0, 0);
    push_req(slbid_pkg::OP_DELETE, 7, 0, 0);
    push_req(slbid_pkg::OP_DELETE, 2, 6, 0);
    push_req(slbid_pkg::OP_DELETE, 2, 2, 0);
    push_req(slbid_pkg::OP_INSERT, 5, 2, 32'h12345678);
    push_req(OP_UNKNOWN, 0, 0, 0);
    push_req(slbid_pkg::OP_INSERT, 1, 1, 32'h5a5a5a5a);
    push_req(slbid_pkg::OP_DELETE, 1, 6, 0);
    gen_random(170);
    wait_drained();

    tx_idle_pct = 49;
    rx_idle_pct = 13;
    gen_random(170);
    wait_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    gen_random(160);
    hold_ask = hold_ask + 1;
    wait_drained();

    // Empty the list, probe the top positions, then open a full-length and an oversized burst.
    if (plan_len != 0) push_req(slbid_pkg::OP_DELETE, 1, plan_len, 0);
    push_req(slbid_pkg::OP_READ, 1024, 0, 0);
    push_req(slbid_pkg::OP_READ, 1025, 0, 0);
    push_req(slbid_pkg::OP_INSERT, 1, LIST_CAP, $urandom);
    push_req(slbid_pkg::OP_INSERT, 0, 0, $urandom);
    push_req(slbid_pkg::OP_DELETE, 1, 2, 0);
    push_req(slbid_pkg::OP_INSERT, 1, LIST_CAP + 1, 8);
    push_req(slbid_pkg::OP_READ, 1, 0, 0);
    wait_drained();

    repeat (TAIL_CYCLES) @(negedge clk);
    $display("Run covered %0d requests and %0d results, list sizes up to %0d entries,",
             n_requests, n_answers, peak_len);
    $display("with %0d successful reads, %0d range and %0d full flags.", n_reads, n_range,
             n_full);
    if (mismatches == 0 && answer_q.size() == 0) begin
      $display("PASS sequential_list_block_insert_delete");
    end else begin
      $display("FAIL sequential_list_block_insert_delete");
    end
    $finish;
  end

endmodule
